/* rtl/core/cgpd_pkg.sv */
package cgpd_pkg;

	localparam int MAX_LABELS = 128;
	localparam int MAX_CHARS  = 32;

	localparam int SCORE_W = 16;
	localparam int LABEL_W = 7;
	localparam int COUNT_W = 6;
	localparam int SUM_W   = 22;
	localparam int POS_W   = $clog2(MAX_LABELS + 1);
	localparam int LIU_W   = 8;
	localparam int RANGE_W = 7;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 2;
	localparam int DIV_CNT_W = $clog2(SUM_W);
	localparam int OUT_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_LABELS_IN_USE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCORE_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW       = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH      = 2'd3;

	localparam logic [LIU_W-1:0]   LABELS_RST    = 8'd84;
	localparam logic [SCORE_W-1:0] THRESHOLD_RST = 16'd22937;
	localparam logic [RANGE_W-1:0] RANGE_LOW_RST = 7'd31;
	localparam logic [RANGE_W-1:0] RANGE_HIGH_RST = 7'd64;

	localparam logic KIND_CHAR    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHAR1,
		ST_CHAR2,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_SUMMARY
	} state_t;

	typedef struct packed {
		logic accept;
		logic keep1;
		logic keep2;
		logic div_start;
		logic emit_sum;
	} cmd_t;

	typedef struct packed {
		logic fin;
		logic k1_valid;
		logic k2_valid;
		logic sum_req;
		logic cap_full;
		logic out_free;
		logic div_busy;
	} sts_t;

endpackage

/* rtl/core/cgpd_div.sv */
module cgpd_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [cgpd_pkg::SUM_W-1:0]  dividend,
	input  logic [cgpd_pkg::COUNT_W-1:0] divisor,
	output logic                        busy,
	output logic [cgpd_pkg::SUM_W-1:0]  quotient
);

	logic [cgpd_pkg::COUNT_W-1:0]   rem_q;
	logic [cgpd_pkg::COUNT_W-1:0]   div_q;
	logic [cgpd_pkg::SUM_W-1:0]     quo_q;
	logic [cgpd_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;

	logic [cgpd_pkg::COUNT_W:0]   shifted;
	logic [cgpd_pkg::COUNT_W+1:0] diff;
	logic                         borrow;

	// restoring division, one quotient bit per cycle
	always_comb begin
		shifted = {rem_q, quo_q[cgpd_pkg::SUM_W-1]};
		diff    = {1'b0, shifted} - {2'b00, div_q};
		borrow  = diff[cgpd_pkg::COUNT_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= cgpd_pkg::DIV_CNT_W'(cgpd_pkg::SUM_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[cgpd_pkg::SUM_W-2:0], ~borrow};
			rem_q <= borrow ? shifted[cgpd_pkg::COUNT_W-1:0] : diff[cgpd_pkg::COUNT_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

/* rtl/core/cgpd_dp.sv */
module cgpd_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cgpd_pkg::cmd_t                 cmd,
	output cgpd_pkg::sts_t                 sts,
	input  logic                           cfg_wr_en,
	input  logic [cgpd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cgpd_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic [cgpd_pkg::SCORE_W-1:0]   in_score,
	input  logic                           in_frame_end,
	input  logic                           in_seq_end,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [cgpd_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                           m_tlast,
	output logic                           m_tuser
);

	localparam int SW = cgpd_pkg::SCORE_W;
	localparam int LW = cgpd_pkg::LABEL_W;
	localparam int CW = cgpd_pkg::COUNT_W;
	localparam int PW = cgpd_pkg::POS_W;

	// configuration
	logic [cgpd_pkg::LIU_W-1:0]   labels_q;
	logic [SW-1:0]                thr_q;
	logic [cgpd_pkg::RANGE_W-1:0] rlow_q;
	logic [cgpd_pkg::RANGE_W-1:0] rhigh_q;

	// frame and sequence state
	logic [SW-1:0] best_q;
	logic [LW-1:0] blbl_q;
	logic [PW-1:0] pos_q;
	logic [LW-1:0] prev_q;
	logic          first_q;
	logic          pend_v_q;
	logic [LW-1:0] pend_lbl_q;
	logic [SW-1:0] pend_sc_q;
	logic [CW-1:0] kept_q;
	logic [cgpd_pkg::SUM_W-1:0] sum_q;
	logic          dropped_q;

	// characters to keep for the current item
	logic          k1v_q, k2v_q, sumreq_q;
	logic [LW-1:0] k1_lbl_q, k2_lbl_q;
	logic [SW-1:0] k1_sc_q, k2_sc_q;

	// output register
	logic          out_valid_q;
	logic          out_kind_q;
	logic [LW-1:0] out_lbl_q;
	logic [SW-1:0] out_conf_q;
	logic [CW-1:0] out_cnt_q;
	logic          out_ovf_q;
	logic          out_last_q;

	logic          div_busy;
	logic [cgpd_pkg::SUM_W-1:0] div_quo;

	logic [PW-1:0] n_eff;
	logic          fin;
	logic          better;
	logic [SW-1:0] nbest;
	logic [LW-1:0] nlbl;
	logic          cand_v;
	logic          w_region;
	logic          k1v_d, k2v_d, pend_v_d;
	logic [LW-1:0] k1_lbl_d, k2_lbl_d, pend_lbl_d;
	logic [SW-1:0] k1_sc_d, k2_sc_d, pend_sc_d;
	logic          cap_full;
	logic          out_free;
	logic          keep_go;
	logic [LW-1:0] keep_lbl;
	logic [SW-1:0] keep_sc;
	logic          keep_last;
	logic          k2_fits;

	always_comb begin
		if (labels_q < cgpd_pkg::LIU_W'(2)) begin
			n_eff = PW'(2);
		end else if (labels_q > cgpd_pkg::LIU_W'(cgpd_pkg::MAX_LABELS)) begin
			n_eff = PW'(cgpd_pkg::MAX_LABELS);
		end else begin
			n_eff = PW'(labels_q);
		end
	end

	assign fin = in_frame_end | in_seq_end;

	// running argmax; scores past the label count are ignored
	always_comb begin
		better = (pos_q < n_eff) && ((pos_q == '0) || (in_score > best_q));
		nbest  = better ? in_score : best_q;
		nlbl   = better ? pos_q[LW-1:0] : blbl_q;
	end

	assign w_region = (nlbl < rlow_q) || (nlbl > rhigh_q);
	assign cand_v   = fin && ({1'b0, nlbl} != PW'(n_eff - 1'b1)) &&
	                  (first_q || (nlbl != prev_q)) && (nbest > thr_q);

	// pair rule on a first region candidate and the candidate after it
	always_comb begin
		k1v_d      = 1'b0;
		k2v_d      = 1'b0;
		k1_lbl_d   = nlbl;
		k1_sc_d    = nbest;
		k2_lbl_d   = nlbl;
		k2_sc_d    = nbest;
		pend_v_d   = pend_v_q;
		pend_lbl_d = pend_lbl_q;
		pend_sc_d  = pend_sc_q;
		if (cand_v) begin
			if (pend_v_q) begin
				pend_v_d = 1'b0;
				k1v_d    = 1'b1;
				if (w_region) begin
					if (!(pend_sc_q < nbest)) begin
						k1_lbl_d = pend_lbl_q;
						k1_sc_d  = pend_sc_q;
					end
				end else begin
					k1_lbl_d = pend_lbl_q;
					k1_sc_d  = pend_sc_q;
					k2v_d    = 1'b1;
				end
			end else if ((kept_q == '0) && !dropped_q && w_region) begin
				pend_v_d   = 1'b1;
				pend_lbl_d = nlbl;
				pend_sc_d  = nbest;
			end else begin
				k1v_d = 1'b1;
			end
		end
		// a lone region candidate is kept at sequence end
		if (in_seq_end && pend_v_d) begin
			pend_v_d = 1'b0;
			k1v_d    = 1'b1;
			k1_lbl_d = pend_lbl_d;
			k1_sc_d  = pend_sc_d;
		end
	end

	assign cap_full = kept_q >= CW'(cgpd_pkg::MAX_CHARS);
	assign out_free = !out_valid_q || m_tready;
	assign keep_go  = cmd.keep1 || cmd.keep2;
	assign keep_lbl = cmd.keep1 ? k1_lbl_q : k2_lbl_q;
	assign keep_sc  = cmd.keep1 ? k1_sc_q : k2_sc_q;
	assign k2_fits  = ({1'b0, kept_q} + 1'b1) < (CW + 1)'(cgpd_pkg::MAX_CHARS);
	assign keep_last = cmd.keep1 ? (!sumreq_q && !(k2v_q && k2_fits)) : !sumreq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			labels_q <= cgpd_pkg::LABELS_RST;
			thr_q    <= cgpd_pkg::THRESHOLD_RST;
			rlow_q   <= cgpd_pkg::RANGE_LOW_RST;
			rhigh_q  <= cgpd_pkg::RANGE_HIGH_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				cgpd_pkg::REG_LABELS_IN_USE:   labels_q <= cfg_wdata[cgpd_pkg::LIU_W-1:0];
				cgpd_pkg::REG_SCORE_THRESHOLD: thr_q    <= cfg_wdata[SW-1:0];
				cgpd_pkg::REG_RANGE_LOW:       rlow_q   <= cfg_wdata[cgpd_pkg::RANGE_W-1:0];
				cgpd_pkg::REG_RANGE_HIGH:      rhigh_q  <= cfg_wdata[cgpd_pkg::RANGE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q     <= '0;
			blbl_q     <= '0;
			pos_q      <= '0;
			prev_q     <= '0;
			first_q    <= 1'b1;
			pend_v_q   <= 1'b0;
			pend_lbl_q <= '0;
			pend_sc_q  <= '0;
			k1v_q      <= 1'b0;
			k2v_q      <= 1'b0;
			sumreq_q   <= 1'b0;
		end else if (cmd.accept) begin
			pend_v_q   <= pend_v_d;
			pend_lbl_q <= pend_lbl_d;
			pend_sc_q  <= pend_sc_d;
			k1v_q      <= k1v_d;
			k2v_q      <= k2v_d;
			sumreq_q   <= in_seq_end;
			if (fin) begin
				best_q  <= '0;
				blbl_q  <= '0;
				pos_q   <= '0;
				prev_q  <= in_seq_end ? '0 : nlbl;
				first_q <= in_seq_end;
			end else begin
				best_q <= nbest;
				blbl_q <= nlbl;
				if (pos_q < n_eff) begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			k1_lbl_q <= k1_lbl_d;
			k1_sc_q  <= k1_sc_d;
			k2_lbl_q <= k2_lbl_d;
			k2_sc_q  <= k2_sc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_q    <= '0;
			sum_q     <= '0;
			dropped_q <= 1'b0;
		end else if (keep_go) begin
			if (cap_full) begin
				dropped_q <= 1'b1;
			end else begin
				kept_q <= kept_q + 1'b1;
				sum_q  <= sum_q + cgpd_pkg::SUM_W'(keep_sc);
			end
		end else if (cmd.emit_sum) begin
			kept_q    <= '0;
			sum_q     <= '0;
			dropped_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((keep_go && !cap_full) || cmd.emit_sum) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (keep_go && !cap_full) begin
			out_kind_q <= cgpd_pkg::KIND_CHAR;
			out_lbl_q  <= keep_lbl;
			out_conf_q <= keep_sc;
			out_cnt_q  <= '0;
			out_ovf_q  <= 1'b0;
			out_last_q <= keep_last;
		end else if (cmd.emit_sum) begin
			out_kind_q <= cgpd_pkg::KIND_SUMMARY;
			out_lbl_q  <= '0;
			out_conf_q <= (kept_q == '0) ? '0 : div_quo[SW-1:0];
			out_cnt_q  <= kept_q;
			out_ovf_q  <= dropped_q;
			out_last_q <= 1'b1;
		end
	end

	cgpd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_q),
		.divisor  (kept_q),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	always_comb begin
		sts.fin      = fin;
		sts.k1_valid = k1v_q;
		sts.k2_valid = k2v_q;
		sts.sum_req  = sumreq_q;
		sts.cap_full = cap_full;
		sts.out_free = out_free;
		sts.div_busy = div_busy;
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {2'b00, out_ovf_q, out_cnt_q, out_conf_q, out_lbl_q};

`ifndef SYNTHESIS
	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(keep_go && !cap_full) || cmd.emit_sum |-> out_free)
		else $error("output register loaded while a result is stalled");
	a_kept_bound: assert property (@(posedge clk) disable iff (!arst_n)
		kept_q <= CW'(cgpd_pkg::MAX_CHARS))
		else $error("kept count beyond capacity");
	a_pending_first: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> (kept_q == '0) && !dropped_q)
		else $error("pending character held after a character was kept");
`endif

endmodule

/* rtl/core/cgpd_ctrl.sv */
module cgpd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  cgpd_pkg::sts_t sts,
	output cgpd_pkg::cmd_t cmd
);

	cgpd_pkg::state_t state_q, state_d;

	logic go1, go2;

	// a slot is done when it is empty, dropped at capacity, or the output takes it
	assign go1 = !sts.k1_valid || sts.cap_full || sts.out_free;
	assign go2 = !sts.k2_valid || sts.cap_full || sts.out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			cgpd_pkg::ST_IDLE: begin
				if (in_valid && sts.fin) begin
					state_d = cgpd_pkg::ST_CHAR1;
				end
			end
			cgpd_pkg::ST_CHAR1: begin
				if (go1) begin
					state_d = cgpd_pkg::ST_CHAR2;
				end
			end
			cgpd_pkg::ST_CHAR2: begin
				if (go2) begin
					state_d = sts.sum_req ? cgpd_pkg::ST_DIV_START : cgpd_pkg::ST_IDLE;
				end
			end
			cgpd_pkg::ST_DIV_START: begin
				state_d = cgpd_pkg::ST_DIV_WAIT;
			end
			cgpd_pkg::ST_DIV_WAIT: begin
				if (!sts.div_busy) begin
					state_d = cgpd_pkg::ST_SUMMARY;
				end
			end
			cgpd_pkg::ST_SUMMARY: begin
				if (sts.out_free) begin
					state_d = cgpd_pkg::ST_IDLE;
				end
			end
			default: state_d = cgpd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		cmd.accept    = 1'b0;
		cmd.keep1     = 1'b0;
		cmd.keep2     = 1'b0;
		cmd.div_start = 1'b0;
		cmd.emit_sum  = 1'b0;
		case (state_q)
			cgpd_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			cgpd_pkg::ST_CHAR1:     cmd.keep1     = sts.k1_valid && (sts.cap_full || sts.out_free);
			cgpd_pkg::ST_CHAR2:     cmd.keep2     = sts.k2_valid && (sts.cap_full || sts.out_free);
			cgpd_pkg::ST_DIV_START: cmd.div_start = 1'b1;
			cgpd_pkg::ST_SUMMARY:   cmd.emit_sum  = sts.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cgpd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	a_frame_end_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && sts.fin |=> state_q == cgpd_pkg::ST_CHAR1)
		else $error("frame end item did not start result dispatch");
	a_summary_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cgpd_pkg::ST_SUMMARY |-> !sts.div_busy)
		else $error("summary reached while divider still busy");
`endif

endmodule

/* rtl/core/ctc_greedy_plate_decoder_unit.sv */
// CTC greedy decoder for plate label scores.
// Input channel s_*: one label score per item, label by label; s_tlast marks
// the last score of a frame, s_tuser the last score of the sequence.
// Output channel m_*: the results of frame-end items; m_tuser 0 is a decoded character,
// 1 the end-of-sequence summary (count, average score, overflow); m_tlast
// marks the final result caused by one input item.
// Config: cfg_wr_en/cfg_index/cfg_wdata write one register per cycle; the user
// must write only while the block is idle, which the block does not enforce.
// Dispatch: a score that does not end a frame leaves the block idle and ready
// for the next score. A frame end goes through the two character slots of the
// dispatch sequencer. A sequence end then starts the bit-serial average
// divider, waits out its 22 steps and loads the summary. The first character
// of a frame end passes from its character slot register into the output register.
// A result waits in the output register while the receiver stalls; new
// scores are still taken then, but the dispatch sequencer holds until the
// register frees up, and s_tready stays low meanwhile.
// Reset clears the sequence state and loads the register defaults.
module ctc_greedy_plate_decoder_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [cgpd_pkg::SCORE_W-1:0]    s_tdata,   // [15:0] score
	input  logic                            s_tlast,
	input  logic                            s_tuser,   // sequence_end
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [6:0] label, [22:7] confidence, [28:23] char_count, [29] overflow, [31:30] zero
	output logic [cgpd_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                            m_tlast,
	output logic                            m_tuser,   // kind
	input  logic                            cfg_wr_en,
	input  logic [cgpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cgpd_pkg::CFG_W-1:0]      cfg_wdata
);

	cgpd_pkg::cmd_t cmd;
	cgpd_pkg::sts_t sts;

	cgpd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cgpd_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_score     (s_tdata),
		.in_frame_end (s_tlast),
		.in_seq_end   (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast),
		.m_tuser      (m_tuser)
	);

endmodule
